/* rtl/core/fus_pkg.sv */
// Shared types, codes and constants for the ftp URL splitter.
`timescale 1ns / 1ps

package fus_pkg;

  // Length limit of one URL and the width of the byte position counter.
  localparam int unsigned MAX_URL_LEN = 256;
  localparam int unsigned POS_W       = $clog2(MAX_URL_LEN + 1);
  localparam int unsigned SCHEME_LEN  = 6;

  // Characters that the parser looks for.
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_F     = 8'h66;
  localparam logic [7:0] CHR_T     = 8'h74;
  localparam logic [7:0] CHR_P     = 8'h70;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_SLASH = 8'h2F;
  localparam logic [7:0] CHR_AT    = 8'h40;

  // Field tags.
  localparam logic [2:0] TAG_NONE = 3'd0;
  localparam logic [2:0] TAG_USER = 3'd1;
  localparam logic [2:0] TAG_PASS = 3'd2;
  localparam logic [2:0] TAG_HOST = 3'd3;
  localparam logic [2:0] TAG_FILE = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_BUSY         = 3'd0;
  localparam logic [2:0] ST_OK           = 3'd1;
  localparam logic [2:0] ST_BAD_PREFIX   = 3'd2;
  localparam logic [2:0] ST_TOO_LONG     = 3'd3;
  localparam logic [2:0] ST_BAD_USER_END = 3'd4;
  localparam logic [2:0] ST_BAD_PASS_END = 3'd5;
  localparam logic [2:0] ST_BAD_HOST_END = 3'd6;

  // Parser phase, one-hot.
  typedef enum logic [5:0] {
    PH_PREFIX  = 6'b000001,
    PH_USER    = 6'b000010,
    PH_PASS    = 6'b000100,
    PH_HOST    = 6'b001000,
    PH_FILE    = 6'b010000,
    PH_DISCARD = 6'b100000
  } phase_t;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    phase_t           phase;
    logic [POS_W-1:0] pos;
    logic [2:0]       err;
    logic             anon;
  } parse_state_t;

  // Per-byte result besides the echoed byte.
  typedef struct packed {
    logic [2:0] tag;
    logic [2:0] status;
    logic       anon;
    logic       fin;
  } parse_result_t;

  localparam parse_state_t STATE_RESET = '{
    phase: PH_PREFIX,
    pos:   '0,
    err:   ST_BUSY,
    anon:  1'b0
  };

  // Expected character of the "ftp://" prefix at a given offset.
  function automatic logic [7:0] scheme_char(input logic [2:0] idx);
    logic [7:0] chr;
    case (idx)
      3'd0:    chr = CHR_F;
      3'd1:    chr = CHR_T;
      3'd2:    chr = CHR_P;
      3'd3:    chr = CHR_COLON;
      3'd4:    chr = CHR_SLASH;
      3'd5:    chr = CHR_SLASH;
      default: chr = CHR_NUL;
    endcase
    return chr;
  endfunction

endpackage

/* rtl/core/fus_step.sv */
// Next-state and result logic of the URL parser for one byte.
`timescale 1ns / 1ps

module fus_step (
  input  logic [7:0]            url_byte,
  input  fus_pkg::parse_state_t cur,
  output fus_pkg::parse_state_t nxt,
  output fus_pkg::parse_result_t res
);
  import fus_pkg::*;

  logic       fin;
  logic       too_long;
  logic [2:0] err;
  logic [2:0] tag;
  logic [2:0] status;
  parse_state_t upd;

  assign fin      = (url_byte == CHR_NUL);
  assign too_long = (cur.pos >= POS_W'(MAX_URL_LEN));

  // Classify the byte according to the current phase.
  always_comb begin
    upd    = cur;
    tag    = TAG_NONE;
    status = ST_BUSY;
    err    = ST_BUSY;
    case (cur.phase)
      PH_DISCARD: begin
        status = cur.err;
      end
      PH_PREFIX: begin
        if (cur.pos >= POS_W'(SCHEME_LEN) || url_byte != scheme_char(cur.pos[2:0])) begin
          err = ST_BAD_PREFIX;
        end else if (cur.pos == POS_W'(SCHEME_LEN - 1)) begin
          upd.phase = PH_USER;
        end
      end
      PH_USER: begin
        if (too_long) begin
          err = ST_TOO_LONG;
        end else if (url_byte == CHR_COLON) begin
          upd.phase = PH_PASS;
        end else if (url_byte == CHR_SLASH) begin
          upd.anon  = 1'b1;
          upd.phase = PH_FILE;
        end else if (fin) begin
          err = ST_BAD_USER_END;
        end else begin
          tag = TAG_USER;
        end
      end
      PH_PASS: begin
        if (too_long) begin
          err = ST_TOO_LONG;
        end else if (url_byte == CHR_AT) begin
          upd.phase = PH_HOST;
        end else if (url_byte == CHR_SLASH || fin) begin
          err = ST_BAD_PASS_END;
        end else begin
          tag = TAG_PASS;
        end
      end
      PH_HOST: begin
        if (too_long) begin
          err = ST_TOO_LONG;
        end else if (url_byte == CHR_SLASH) begin
          upd.phase = PH_FILE;
        end else if (fin) begin
          err = ST_BAD_HOST_END;
        end else begin
          tag = TAG_HOST;
        end
      end
      PH_FILE: begin
        if (too_long) begin
          err = ST_TOO_LONG;
        end else if (fin) begin
          status = ST_OK;
        end else begin
          tag = TAG_FILE;
        end
      end
      default: begin
        upd.phase = PH_DISCARD;
        status    = cur.err;
      end
    endcase

    // An error is held and the rest of the URL is discarded.
    if (err != ST_BUSY) begin
      upd.err   = err;
      upd.phase = PH_DISCARD;
      status    = err;
    end

    // The position saturates at the length limit.
    if (!too_long) begin
      upd.pos = cur.pos + POS_W'(1);
    end
  end

  // A zero byte closes the URL and restarts the parser.
  always_comb begin
    res.tag    = tag;
    res.status = status;
    res.anon   = upd.anon;
    res.fin    = fin;
    nxt        = fin ? STATE_RESET : upd;
  end

endmodule

/* rtl/core/ftp_url_splitter_unit.sv */
// Top level of the ftp URL splitter: input register, parser state and result register.
// A word goes from the input register through the parser into the result register.
// Throughput: one word per cycle when the sink does not stall; the input and result
// registers form a two-entry pipe; a new word is taken while a result waits for the sink.
// Reset: synchronous, active low; clears the pipe valids and returns the parser
// to the prefix phase with position, held error and anonymous flag at zero.
`timescale 1ns / 1ps

module ftp_url_splitter_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_url_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_echo_byte,
  output logic [2:0] out_field_tag,
  output logic [2:0] out_status_code,
  output logic       out_first_is_host,
  output logic       out_url_end
);
  import fus_pkg::*;

  logic          s1_valid_r;
  logic          s1_valid_nxt;
  logic [7:0]    s1_byte_r;
  logic          s1_adv;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic [7:0]    out_byte_r;
  parse_result_t out_res_r;
  parse_state_t  state_r;
  parse_state_t  state_nxt;
  parse_result_t step_res;

  // The input word moves on when the result register is free or being drained.
  assign s1_adv        = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall      = s1_valid_r && !s1_adv;
  assign s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_valid_r && out_stall);

  fus_step u_step (
    .url_byte (s1_byte_r),
    .cur      (state_r),
    .nxt      (state_nxt),
    .res      (step_res)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte_r <= in_url_byte;
    end
    if (s1_adv) begin
      out_byte_r <= s1_byte_r;
      out_res_r  <= step_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_echo_byte     = out_byte_r;
  assign out_field_tag     = out_res_r.tag;
  assign out_status_code   = out_res_r.status;
  assign out_first_is_host = out_res_r.anon;
  assign out_url_end       = out_res_r.fin;

`ifndef ASSERT_OFF
  // Success is only ever reported on the closing zero byte.
  a_ok_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status_code == ST_OK |-> out_url_end)
    else $error("ok status without end of URL");

  // A byte tagged as part of a field never carries a status.
  a_tag_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_field_tag != TAG_NONE |-> out_status_code == ST_BUSY)
    else $error("field byte carries a status");

  // After a closing zero byte the parser is back in its reset state.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_byte_r == CHR_NUL |=> state_r == STATE_RESET)
    else $error("parser did not restart after end of URL");

  // The input only stalls while a word is held in the input register.
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");
`endif

endmodule
